// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle of the antecedent.
`define FK_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Expression must never be true out of reset.
`define FK_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("assertion failed");

`endif

// ----- design/fk_pkg.sv -----
// Shared constants, types and tables for the arm forward kinematics block.
`default_nettype none

package fk_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int FRAC_BITS     = 16;
    localparam int LEN_BITS      = 17;
    localparam int POS_BITS      = 21;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [63:0] CORDIC_GAIN_Q32 = 64'h0000_0000_9B74_EDA8;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BASE_HEIGHT   = 3'd0,
        CFG_UPPER_ARM     = 3'd1,
        CFG_FOREARM       = 3'd2,
        CFG_SHOULDER_OFS  = 3'd3,
        CFG_WRIST_TWO_OFS = 3'd4,
        CFG_FLANGE_OFS    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [LEN_BITS-1:0] base_height;
        logic [LEN_BITS-1:0] upper_arm_length;
        logic [LEN_BITS-1:0] forearm_length;
        logic [LEN_BITS-1:0] shoulder_offset;
        logic [LEN_BITS-1:0] wrist_two_offset;
        logic [LEN_BITS-1:0] flange_offset;
    } t_links;

    // arctangent of 2^-i, 2^32 per turn
    function automatic logic [31:0] atan_turns(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            20:      v = 32'd652;
            21:      v = 32'd326;
            22:      v = 32'd163;
            23:      v = 32'd81;
            24:      v = 32'd41;
            25:      v = 32'd20;
            26:      v = 32'd10;
            27:      v = 32'd5;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- design/fk_sincos.sv -----
// Pipelined CORDIC cosine and sine of one binary angle, one step per stage.
`default_nettype none

module fk_sincos #(
    parameter int ANGLE_BITS = fk_pkg::ANGLE_BITS,
    parameter int FRAC_BITS  = fk_pkg::FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic        [ANGLE_BITS-1:0]  i_angle,
    output logic signed      [FRAC_BITS+1:0]   o_cos,
    output logic signed      [FRAC_BITS+1:0]   o_sin
);

    localparam int W     = FRAC_BITS + 4;
    localparam int XW    = FRAC_BITS + 6;
    localparam int STEPS = FRAC_BITS + 2;
    localparam logic [63:0] X_INIT =
        (fk_pkg::CORDIC_GAIN_Q32 + (64'd1 << (31 - W))) >> (32 - W);
    localparam logic signed [XW-1:0] ONE_P = XW'(1) <<< FRAC_BITS;
    localparam logic signed [XW-1:0] ONE_N = -ONE_P;

    logic signed [XW-1:0] r_x   [STEPS+1];
    logic signed [XW-1:0] r_y   [STEPS+1];
    logic        [31:0]   r_z   [STEPS+1];
    logic                 r_neg [STEPS+1];

    logic [31:0] n_z0;
    logic        n_neg0;

    assign n_z0   = {i_angle, (32 - ANGLE_BITS)'(0)};
    assign n_neg0 = n_z0[31] ^ n_z0[30];

    always_ff @(posedge i_clk) begin
        r_z[0]   <= n_neg0 ? (n_z0 ^ 32'h8000_0000) : n_z0;
        r_neg[0] <= n_neg0;
        r_x[0]   <= X_INIT[XW-1:0];
        r_y[0]   <= '0;
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam logic [31:0] ATAN = fk_pkg::atan_turns(i);
        logic signed [XW-1:0] n_x;
        logic signed [XW-1:0] n_y;
        logic        [31:0]   n_z;

        assign n_x = r_z[i][31] ? (r_x[i] + (r_y[i] >>> i)) : (r_x[i] - (r_y[i] >>> i));
        assign n_y = r_z[i][31] ? (r_y[i] - (r_x[i] >>> i)) : (r_y[i] + (r_x[i] >>> i));
        assign n_z = r_z[i][31] ? (r_z[i] + ATAN) : (r_z[i] - ATAN);

        always_ff @(posedge i_clk) begin
            r_x[i+1]   <= n_x;
            r_y[i+1]   <= n_y;
            r_z[i+1]   <= n_z;
            r_neg[i+1] <= r_neg[i];
        end
    end

    logic signed [XW-1:0] n_xr;
    logic signed [XW-1:0] n_yr;
    logic signed [XW-1:0] n_xs;
    logic signed [XW-1:0] n_ys;
    logic signed [XW-1:0] n_xc;
    logic signed [XW-1:0] n_yc;

    always_comb begin
        n_xr = (r_x[STEPS] + XW'(8)) >>> 4;
        n_yr = (r_y[STEPS] + XW'(8)) >>> 4;
        n_xs = r_neg[STEPS] ? -n_xr : n_xr;
        n_ys = r_neg[STEPS] ? -n_yr : n_yr;
        n_xc = (n_xs > ONE_P) ? ONE_P : ((n_xs < ONE_N) ? ONE_N : n_xs);
        n_yc = (n_ys > ONE_P) ? ONE_P : ((n_ys < ONE_N) ? ONE_N : n_ys);
    end

    always_ff @(posedge i_clk) begin
        o_cos <= n_xc[FRAC_BITS+1:0];
        o_sin <= n_yc[FRAC_BITS+1:0];
    end

endmodule

`default_nettype wire

// ----- design/fk_chain.sv -----
// Pipelined closed-form product of the joint rotations and link offsets.
`default_nettype none

module fk_chain #(
    parameter int FRAC_BITS = fk_pkg::FRAC_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic signed [FRAC_BITS+1:0]     i_cos [6],
    input  wire logic signed [FRAC_BITS+1:0]     i_sin [6],
    input  wire fk_pkg::t_links                  i_links,
    output logic signed      [FRAC_BITS+1:0]     o_rot [9],
    output logic signed      [fk_pkg::POS_BITS-1:0] o_pos [3]
);

    localparam int MW = (FRAC_BITS + 6 > 28) ? FRAC_BITS + 6 : 28;
    localparam int PB = fk_pkg::POS_BITS;

    typedef logic signed [MW-1:0]   t_w;
    typedef logic signed [2*MW-1:0] t_p;

    localparam t_w ONE_P = t_w'(1) <<< FRAC_BITS;
    localparam t_w ONE_N = -ONE_P;
    localparam t_w POS_HI = (t_w'(1) <<< (PB - 1)) - t_w'(1);
    localparam t_w POS_LO = -(t_w'(1) <<< (PB - 1));

    function automatic t_w mulw(input t_w a, input t_w b);
        t_p p;
        p = t_p'(a) * t_p'(b) + (t_p'(1) <<< (FRAC_BITS - 1));
        return p[FRAC_BITS+MW-1:FRAC_BITS];
    endfunction

    t_w e_c [6];
    t_w e_s [6];
    t_w d1, a2, a3, d4, d5, d6;

    for (genvar k = 0; k < 6; k++) begin : g_ext
        assign e_c[k] = t_w'(i_cos[k]);
        assign e_s[k] = t_w'(i_sin[k]);
    end

    assign d1 = t_w'(i_links.base_height);
    assign a2 = t_w'(i_links.upper_arm_length);
    assign a3 = t_w'(i_links.forearm_length);
    assign d4 = t_w'(i_links.shoulder_offset);
    assign d5 = t_w'(i_links.wrist_two_offset);
    assign d6 = t_w'(i_links.flange_offset);

    // stage 1
    t_w r1_c [6];
    t_w r1_s [6];
    t_w r1_c23, r1_s23, r1_c1c2, r1_s1c2;

    always_ff @(posedge i_clk) begin
        r1_c    <= e_c;
        r1_s    <= e_s;
        r1_c23  <= mulw(e_c[1], e_c[2]) - mulw(e_s[1], e_s[2]);
        r1_s23  <= mulw(e_c[1], e_s[2]) + mulw(e_s[1], e_c[2]);
        r1_c1c2 <= mulw(e_c[0], e_c[1]);
        r1_s1c2 <= mulw(e_s[0], e_c[1]);
    end

    // stage 2
    t_w r2_c [6];
    t_w r2_s [6];
    t_w r2_c234, r2_s234, r2_c1c23, r2_s1c23, r2_c1c2, r2_s1c2, r2_s23;

    always_ff @(posedge i_clk) begin
        r2_c     <= r1_c;
        r2_s     <= r1_s;
        r2_c234  <= mulw(r1_c23, r1_c[3]) - mulw(r1_s23, r1_s[3]);
        r2_s234  <= mulw(r1_s23, r1_c[3]) + mulw(r1_c23, r1_s[3]);
        r2_c1c23 <= mulw(r1_c[0], r1_c23);
        r2_s1c23 <= mulw(r1_s[0], r1_c23);
        r2_c1c2  <= r1_c1c2;
        r2_s1c2  <= r1_s1c2;
        r2_s23   <= r1_s23;
    end

    // stage 3
    t_w r3_c [6];
    t_w r3_s [6];
    t_w r3_u0, r3_v0, r3_u1, r3_v1, r3_w2, r3_r8, r3_c234, r3_px, r3_py, r3_pz;

    always_ff @(posedge i_clk) begin
        r3_c    <= r2_c;
        r3_s    <= r2_s;
        r3_c234 <= r2_c234;
        r3_u0   <= mulw(r2_c[0], r2_c234);
        r3_v0   <= mulw(r2_c[0], r2_s234);
        r3_u1   <= mulw(r2_s[0], r2_c234);
        r3_v1   <= mulw(r2_s[0], r2_s234);
        r3_w2   <= mulw(r2_s234, r2_c[4]);
        r3_r8   <= -mulw(r2_s234, r2_s[4]);
        r3_px   <= mulw(a3, r2_c1c23) + mulw(a2, r2_c1c2) + mulw(d4, r2_s[0]);
        r3_py   <= mulw(a3, r2_s1c23) + mulw(a2, r2_s1c2) - mulw(d4, r2_c[0]);
        r3_pz   <= mulw(a3, r2_s23) + mulw(a2, r2_s[1]) + d1 - mulw(d5, r2_c234);
    end

    // stage 4
    t_w r4_c6, r4_s6, r4_v0, r4_v1, r4_w0, r4_w1;
    t_w r4_r2, r4_r5, r4_r6, r4_r7, r4_r8, r4_px, r4_py, r4_pz;

    always_ff @(posedge i_clk) begin
        r4_c6 <= r3_c[5];
        r4_s6 <= r3_s[5];
        r4_v0 <= r3_v0;
        r4_v1 <= r3_v1;
        r4_w0 <= mulw(r3_s[0], r3_s[4]) + mulw(r3_u0, r3_c[4]);
        r4_w1 <= mulw(r3_u1, r3_c[4]) - mulw(r3_c[0], r3_s[4]);
        r4_r2 <= mulw(r3_s[0], r3_c[4]) - mulw(r3_u0, r3_s[4]);
        r4_r5 <= -mulw(r3_u1, r3_s[4]) - mulw(r3_c[0], r3_c[4]);
        r4_r6 <= mulw(r3_c234, r3_s[5]) + mulw(r3_w2, r3_c[5]);
        r4_r7 <= mulw(r3_c234, r3_c[5]) - mulw(r3_w2, r3_s[5]);
        r4_r8 <= r3_r8;
        r4_px <= r3_px + mulw(d5, r3_v0);
        r4_py <= r3_py + mulw(d5, r3_v1);
        r4_pz <= r3_pz + mulw(d6, r3_r8);
    end

    // stage 5
    t_w r5_rot [9];
    t_w r5_pos [3];

    always_ff @(posedge i_clk) begin
        r5_rot[0] <= mulw(r4_w0, r4_c6) - mulw(r4_v0, r4_s6);
        r5_rot[1] <= -mulw(r4_v0, r4_c6) - mulw(r4_w0, r4_s6);
        r5_rot[2] <= r4_r2;
        r5_rot[3] <= mulw(r4_w1, r4_c6) - mulw(r4_v1, r4_s6);
        r5_rot[4] <= -mulw(r4_v1, r4_c6) - mulw(r4_w1, r4_s6);
        r5_rot[5] <= r4_r5;
        r5_rot[6] <= r4_r6;
        r5_rot[7] <= r4_r7;
        r5_rot[8] <= r4_r8;
        r5_pos[0] <= r4_px + mulw(d6, r4_r2);
        r5_pos[1] <= r4_py + mulw(d6, r4_r5);
        r5_pos[2] <= r4_pz;
    end

    // stage 6: saturation
    for (genvar k = 0; k < 9; k++) begin : g_rot
        t_w n_rc;
        assign n_rc = (r5_rot[k] > ONE_P) ? ONE_P : ((r5_rot[k] < ONE_N) ? ONE_N : r5_rot[k]);
        always_ff @(posedge i_clk) begin
            o_rot[k] <= n_rc[FRAC_BITS+1:0];
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_pos
        t_w n_pc;
        assign n_pc = (r5_pos[k] > POS_HI) ? POS_HI :
                      ((r5_pos[k] < POS_LO) ? POS_LO : r5_pos[k]);
        always_ff @(posedge i_clk) begin
            o_pos[k] <= n_pc[PB-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- design/six_joint_arm_forward_kinematics.sv -----
// Top level: six-joint arm forward kinematics, fully pipelined.
// Throughput: one pose per cycle; busy is never raised.
// CORDIC runs one step per stage for all six joints, then six product and saturation stages.
// Synchronous active-low reset clears the valid pipeline and link registers.
`default_nettype none

module six_joint_arm_forward_kinematics #(
    parameter int ANGLE_BITS = fk_pkg::ANGLE_BITS,
    parameter int FRAC_BITS  = fk_pkg::FRAC_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    output logic                                       o_busy,
    input  wire logic        [ANGLE_BITS-1:0]          i_angle_base,
    input  wire logic        [ANGLE_BITS-1:0]          i_angle_shoulder,
    input  wire logic        [ANGLE_BITS-1:0]          i_angle_elbow,
    input  wire logic        [ANGLE_BITS-1:0]          i_angle_wrist_one,
    input  wire logic        [ANGLE_BITS-1:0]          i_angle_wrist_two,
    input  wire logic        [ANGLE_BITS-1:0]          i_angle_wrist_three,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic        [fk_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic        [fk_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output logic                                       o_done,
    output logic signed      [FRAC_BITS+1:0]           o_rot_xx,
    output logic signed      [FRAC_BITS+1:0]           o_rot_xy,
    output logic signed      [FRAC_BITS+1:0]           o_rot_xz,
    output logic signed      [FRAC_BITS+1:0]           o_rot_yx,
    output logic signed      [FRAC_BITS+1:0]           o_rot_yy,
    output logic signed      [FRAC_BITS+1:0]           o_rot_yz,
    output logic signed      [FRAC_BITS+1:0]           o_rot_zx,
    output logic signed      [FRAC_BITS+1:0]           o_rot_zy,
    output logic signed      [FRAC_BITS+1:0]           o_rot_zz,
    output logic signed      [fk_pkg::POS_BITS-1:0]    o_pos_x,
    output logic signed      [fk_pkg::POS_BITS-1:0]    o_pos_y,
    output logic signed      [fk_pkg::POS_BITS-1:0]    o_pos_z
);

    localparam int LAT = FRAC_BITS + 10;

    fk_pkg::t_links r_links;
    logic [LAT-1:0] r_vld;

    logic [ANGLE_BITS-1:0] w_angle [6];
    logic signed [FRAC_BITS+1:0] w_cos [6];
    logic signed [FRAC_BITS+1:0] w_sin [6];
    logic signed [FRAC_BITS+1:0] w_rot [9];
    logic signed [fk_pkg::POS_BITS-1:0] w_pos [3];

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_links <= '0;
            r_vld   <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_start & ~o_busy};
            if (i_cfg_valid && o_cfg_ready) begin
                case (fk_pkg::t_cfg_idx'(i_cfg_index))
                    fk_pkg::CFG_BASE_HEIGHT:
                        r_links.base_height <= i_cfg_data[fk_pkg::LEN_BITS-1:0];
                    fk_pkg::CFG_UPPER_ARM:
                        r_links.upper_arm_length <= i_cfg_data[fk_pkg::LEN_BITS-1:0];
                    fk_pkg::CFG_FOREARM:
                        r_links.forearm_length <= i_cfg_data[fk_pkg::LEN_BITS-1:0];
                    fk_pkg::CFG_SHOULDER_OFS:
                        r_links.shoulder_offset <= i_cfg_data[fk_pkg::LEN_BITS-1:0];
                    fk_pkg::CFG_WRIST_TWO_OFS:
                        r_links.wrist_two_offset <= i_cfg_data[fk_pkg::LEN_BITS-1:0];
                    fk_pkg::CFG_FLANGE_OFS:
                        r_links.flange_offset <= i_cfg_data[fk_pkg::LEN_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign w_angle[0] = i_angle_base;
    assign w_angle[1] = i_angle_shoulder;
    assign w_angle[2] = i_angle_elbow;
    assign w_angle[3] = i_angle_wrist_one;
    assign w_angle[4] = i_angle_wrist_two;
    assign w_angle[5] = i_angle_wrist_three;

    for (genvar k = 0; k < 6; k++) begin : g_joint
        fk_sincos #(
            .ANGLE_BITS (ANGLE_BITS),
            .FRAC_BITS  (FRAC_BITS)
        ) u_sincos (
            .i_clk   (i_clk),
            .i_angle (w_angle[k]),
            .o_cos   (w_cos[k]),
            .o_sin   (w_sin[k])
        );
    end

    fk_chain #(
        .FRAC_BITS (FRAC_BITS)
    ) u_chain (
        .i_clk   (i_clk),
        .i_cos   (w_cos),
        .i_sin   (w_sin),
        .i_links (r_links),
        .o_rot   (w_rot),
        .o_pos   (w_pos)
    );

    assign o_done   = r_vld[LAT-1];
    assign o_rot_xx = w_rot[0];
    assign o_rot_xy = w_rot[1];
    assign o_rot_xz = w_rot[2];
    assign o_rot_yx = w_rot[3];
    assign o_rot_yy = w_rot[4];
    assign o_rot_yz = w_rot[5];
    assign o_rot_zx = w_rot[6];
    assign o_rot_zy = w_rot[7];
    assign o_rot_zz = w_rot[8];
    assign o_pos_x  = w_pos[0];
    assign o_pos_y  = w_pos[1];
    assign o_pos_z  = w_pos[2];

endmodule

`default_nettype wire

// ----- design/fk_checker.sv -----
// Port-level checks for the arm forward kinematics block, with its bind.
`default_nettype none
`include "assert_macros.svh"

module fk_checker #(
    parameter int LAT       = 26,
    parameter int FRAC_BITS = 16
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_start,
    input wire logic                        i_busy,
    input wire logic                        i_cfg_ready,
    input wire logic                        i_done,
    input wire logic signed [FRAC_BITS+1:0] i_rot_xx,
    input wire logic signed [FRAC_BITS+1:0] i_rot_zz
);

    localparam logic signed [FRAC_BITS+1:0] ONE_P = (FRAC_BITS+2)'(1) <<< FRAC_BITS;
    localparam logic signed [FRAC_BITS+1:0] ONE_N = -ONE_P;

    `FK_ASSERT_NEVER(a_never_busy, i_clk, i_rst_n, i_busy || !i_cfg_ready)
    `FK_ASSERT_IMPL(a_done_has_transfer, i_clk, i_rst_n, i_done, $past(i_start && !i_busy, LAT))
    `FK_ASSERT_IMPL(a_xx_range, i_clk, i_rst_n, i_done, (i_rot_xx <= ONE_P) && (i_rot_xx >= ONE_N))
    `FK_ASSERT_IMPL(a_zz_range, i_clk, i_rst_n, i_done, (i_rot_zz <= ONE_P) && (i_rot_zz >= ONE_N))

endmodule

bind six_joint_arm_forward_kinematics fk_checker #(
    .LAT       (LAT),
    .FRAC_BITS (FRAC_BITS)
) u_fk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .i_busy      (o_busy),
    .i_cfg_ready (o_cfg_ready),
    .i_done      (o_done),
    .i_rot_xx    (o_rot_xx),
    .i_rot_zz    (o_rot_zz)
);

`default_nettype wire

// ----- sim/six_joint_arm_forward_kinematics_tb.sv -----
// Testbench for the six-joint arm forward kinematics block, with a built-in predictor.
`timescale 1ns / 1ps

module six_joint_arm_forward_kinematics_tb;

    localparam int ROT_W      = fk_pkg::FRAC_BITS + 2;
    localparam int WORK_W     = fk_pkg::FRAC_BITS + 4;
    localparam int STEPS      = fk_pkg::FRAC_BITS + 2;
    localparam int LATENCY    = fk_pkg::FRAC_BITS + 10;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic [fk_pkg::ANGLE_BITS-1:0] ang [6];
    } t_pose;

    typedef struct {
        logic signed [ROT_W-1:0]            rot [9];
        logic signed [fk_pkg::POS_BITS-1:0] pos [3];
    } t_tool_frame;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic o_busy;
    logic [fk_pkg::ANGLE_BITS-1:0] i_angle_base = '0, i_angle_shoulder = '0;
    logic [fk_pkg::ANGLE_BITS-1:0] i_angle_elbow = '0;
    logic [fk_pkg::ANGLE_BITS-1:0] i_angle_wrist_one = '0, i_angle_wrist_two = '0;
    logic [fk_pkg::ANGLE_BITS-1:0] i_angle_wrist_three = '0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [fk_pkg::CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [fk_pkg::CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic o_done;
    logic signed [ROT_W-1:0] o_rot_xx, o_rot_xy, o_rot_xz, o_rot_yx, o_rot_yy, o_rot_yz;
    logic signed [ROT_W-1:0] o_rot_zx, o_rot_zy, o_rot_zz;
    logic signed [fk_pkg::POS_BITS-1:0] o_pos_x, o_pos_y, o_pos_z;

    six_joint_arm_forward_kinematics dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    longint link_len [6];
    t_tool_frame expected_frames [$];
    int  error_count = 0;
    longint cycle_count = 0;

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint fxmul(longint a, longint b);
        return fshr(a * b + (longint'(1) << (fk_pkg::FRAC_BITS - 1)), fk_pkg::FRAC_BITS);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void joint_sincos(logic [fk_pkg::ANGLE_BITS-1:0] a,
                                         output longint c, output longint s);
        logic [31:0] z;
        logic fold;
        longint x, y, dx, dy, one;
        one = longint'(1) << fk_pkg::FRAC_BITS;
        z = 32'(a) << (32 - fk_pkg::ANGLE_BITS);
        fold = (z[31:30] == 2'd1) || (z[31:30] == 2'd2);
        if (fold) z = z - 32'h8000_0000;
        x = longint'((fk_pkg::CORDIC_GAIN_Q32 + (64'd1 << (31 - WORK_W))) >> (32 - WORK_W));
        y = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (!z[31]) begin
                x -= dx; y += dy; z -= fk_pkg::atan_turns(i);
            end else begin
                x += dx; y -= dy; z += fk_pkg::atan_turns(i);
            end
        end
        x = fshr(x + 8, 4);
        y = fshr(y + 8, 4);
        if (fold) begin
            x = -x; y = -y;
        end
        c = clip(x, -one, one);
        s = clip(y, -one, one);
    endfunction

    function automatic t_tool_frame tool_frame(t_pose p);
        longint c [6], s [6];
        longint c23, s23, c234, s234, u0, v0, w0, u1, v1, w1, w2, one, plo, phi;
        longint r [9], q [3];
        t_tool_frame f;
        one = longint'(1) << fk_pkg::FRAC_BITS;
        plo = -(longint'(1) << (fk_pkg::POS_BITS - 1));
        phi = (longint'(1) << (fk_pkg::POS_BITS - 1)) - 1;
        for (int j = 0; j < 6; j++) joint_sincos(p.ang[j], c[j], s[j]);
        c23  = fxmul(c[1], c[2]) - fxmul(s[1], s[2]);
        s23  = fxmul(c[1], s[2]) + fxmul(s[1], c[2]);
        c234 = fxmul(c23, c[3]) - fxmul(s23, s[3]);
        s234 = fxmul(s23, c[3]) + fxmul(c23, s[3]);
        u0 = fxmul(c[0], c234); v0 = fxmul(c[0], s234);
        w0 = fxmul(s[0], s[4]) + fxmul(u0, c[4]);
        r[0] = fxmul(w0, c[5]) - fxmul(v0, s[5]);
        r[1] = -fxmul(v0, c[5]) - fxmul(w0, s[5]);
        r[2] = fxmul(s[0], c[4]) - fxmul(u0, s[4]);
        u1 = fxmul(s[0], c234); v1 = fxmul(s[0], s234);
        w1 = fxmul(u1, c[4]) - fxmul(c[0], s[4]);
        r[3] = fxmul(w1, c[5]) - fxmul(v1, s[5]);
        r[4] = -fxmul(v1, c[5]) - fxmul(w1, s[5]);
        r[5] = -fxmul(u1, s[4]) - fxmul(c[0], c[4]);
        w2 = fxmul(s234, c[4]);
        r[6] = fxmul(c234, s[5]) + fxmul(w2, c[5]);
        r[7] = fxmul(c234, c[5]) - fxmul(w2, s[5]);
        r[8] = -fxmul(s234, s[4]);
        q[0] = fxmul(link_len[5], r[2]) + fxmul(link_len[4], v0)
             + fxmul(link_len[2], fxmul(c[0], c23)) + fxmul(link_len[1], fxmul(c[0], c[1]))
             + fxmul(link_len[3], s[0]);
        q[1] = fxmul(link_len[5], r[5]) + fxmul(link_len[4], v1)
             + fxmul(link_len[2], fxmul(s[0], c23)) + fxmul(link_len[1], fxmul(s[0], c[1]))
             - fxmul(link_len[3], c[0]);
        q[2] = fxmul(link_len[5], r[8]) - fxmul(link_len[4], c234)
             + fxmul(link_len[2], s23) + fxmul(link_len[1], s[1]) + link_len[0];
        for (int k = 0; k < 9; k++) f.rot[k] = ROT_W'(clip(r[k], -one, one));
        for (int k = 0; k < 3; k++) f.pos[k] = fk_pkg::POS_BITS'(clip(q[k], plo, phi));
        return f;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_tool_frame exp_f, got;
        if (i_rst_n && o_done) begin
            got.rot = '{o_rot_xx, o_rot_xy, o_rot_xz, o_rot_yx, o_rot_yy, o_rot_yz,
                        o_rot_zx, o_rot_zy, o_rot_zz};
            got.pos = '{o_pos_x, o_pos_y, o_pos_z};
            if (expected_frames.size() == 0) begin
                $display("%0t: unexpected result transfer", $time);
                error_count++;
            end else begin
                exp_f = expected_frames.pop_front();
                for (int k = 0; k < 9; k++)
                    if (got.rot[k] !== exp_f.rot[k]) begin
                        $display("%0t: rot[%0d] expected %0d actual %0d",
                                 $time, k, exp_f.rot[k], got.rot[k]);
                        error_count++;
                    end
                for (int k = 0; k < 3; k++)
                    if (got.pos[k] !== exp_f.pos[k]) begin
                        $display("%0t: pos[%0d] expected %0d actual %0d",
                                 $time, k, exp_f.pos[k], got.pos[k]);
                        error_count++;
                    end
            end
        end
    end

    task automatic send_pose(t_pose p);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start             <= 1'b1;
        i_angle_base        <= p.ang[0];
        i_angle_shoulder    <= p.ang[1];
        i_angle_elbow       <= p.ang[2];
        i_angle_wrist_one   <= p.ang[3];
        i_angle_wrist_two   <= p.ang[4];
        i_angle_wrist_three <= p.ang[5];
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        expected_frames.push_back(tool_frame(p));
    endtask

    task automatic write_link(fk_pkg::t_cfg_idx idx, logic [fk_pkg::CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        link_len[idx] = data[fk_pkg::LEN_BITS-1:0];
    endtask

    task automatic wait_idle();
        i_start <= 1'b0;
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_links(logic [fk_pkg::CFG_DATA_BITS-1:0] d [6]);
        wait_idle();
        for (int i = 0; i < 6; i++) write_link(fk_pkg::t_cfg_idx'(i), d[i]);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_pose random_pose();
        t_pose p;
        for (int j = 0; j < 6; j++) begin
            case ($urandom_range(0, 5))
                0:       p.ang[j] = fk_pkg::ANGLE_BITS'($urandom_range(0, 3)
                                    << (fk_pkg::ANGLE_BITS - 2));
                1:       p.ang[j] = fk_pkg::ANGLE_BITS'(($urandom_range(0, 7)
                                    << (fk_pkg::ANGLE_BITS - 3))
                                    + $urandom_range(0, 2) - 1);
                default: p.ang[j] = fk_pkg::ANGLE_BITS'($urandom);
            endcase
        end
        return p;
    endfunction

    task automatic test_directed_poses();
        t_pose p;
        logic [fk_pkg::ANGLE_BITS-1:0] corner [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                                      16'h7FFF, 16'hFFFF, 16'h3FFF, 16'h2000};
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 6; j++) p.ang[j] = corner[i];
            send_pose(p);
        end
        for (int i = 0; i < 6; i++) begin
            for (int j = 0; j < 6; j++) p.ang[j] = corner[(i + j) % 8];
            send_pose(p);
        end
    endtask

    task automatic test_random_poses(int n);
        for (int i = 0; i < n; i++) send_pose(random_pose());
    endtask

    task automatic test_link_settings();
        logic [fk_pkg::CFG_DATA_BITS-1:0] d [6];
        // all links at max
        d = '{32'h1FFFF, 32'h1FFFF, 32'h1FFFF, 32'h1FFFF, 32'h1FFFF, 32'h1FFFF};
        set_links(d);
        test_directed_poses();
        test_random_poses(100);
        // upper bits must be ignored
        for (int i = 0; i < 6; i++) d[i] = $urandom;
        set_links(d);
        test_random_poses(150);
        // out-of-range index has no effect
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= 3'd7;
        i_cfg_data  <= 32'h0001_2345;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_index <= 3'd6;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        test_random_poses(50);
        for (int i = 0; i < 6; i++) d[i] = $urandom_range(0, 40000);
        set_links(d);
        test_random_poses(100);
    endtask

    initial begin
        for (int i = 0; i < 6; i++) link_len[i] = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_poses();
        test_random_poses(80);
        test_link_settings();
        wait_idle();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/fk_pkg.sv
design/fk_sincos.sv
design/fk_chain.sv
design/six_joint_arm_forward_kinematics.sv
design/fk_checker.sv
sim/six_joint_arm_forward_kinematics_tb.sv
